FILE: hdl/motor_limit_switch_interlock_macros.svh
// Assertion macros shared by the interlock RTL.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef MOTOR_LIMIT_SWITCH_INTERLOCK_MACROS_SVH
`define MOTOR_LIMIT_SWITCH_INTERLOCK_MACROS_SVH

// Checked at every clock edge outside reset.
`define MLSI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MLSI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/mlsi_pkg.sv
// Types and constants for the motor limit-switch interlock.
// No dependencies; used by all interlock modules.
package mlsi_pkg;

   localparam int NUM_MOTORS     = 8;
   localparam int WORD_W         = 16;
   localparam int PAIRS_IN_WORD  = WORD_W / 2;
   localparam int MOTORS_CHECKED = (NUM_MOTORS < PAIRS_IN_WORD) ? NUM_MOTORS : PAIRS_IN_WORD;
   localparam int COUNT_W        = 8;

   localparam logic [1:0] PAIR_FWD = 2'b01;
   localparam logic [1:0] PAIR_BWD = 2'b10;
   localparam logic [COUNT_W-1:0] OVERFLOW_READING = 8'd255;

   // CSR indexes
   localparam logic [2:0] CSR_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_STOP_EN  = 3'd1;
   localparam logic [2:0] CSR_STOP_INV = 3'd2;
   localparam logic [2:0] CSR_FWD_PAT  = 3'd3;
   localparam logic [2:0] CSR_BWD_PAT  = 3'd4;

   typedef enum logic [1:0] {
      POT_INIT  = 2'd0,
      POT_ARM   = 2'd1,
      POT_XDONE = 2'd2,
      POT_YDONE = 2'd3
   } pot_phase_type;

   typedef struct packed {
      logic [WORD_W-1:0] stop_enable;
      logic [WORD_W-1:0] stop_invert;
      logic [WORD_W-1:0] fwd_pattern;
      logic [WORD_W-1:0] bwd_pattern;
   } stop_cfg_type;

   typedef struct packed {
      logic counter_clear;
      logic trigger_x;
      logic trigger_y;
      logic pot_x_changed;
      logic pot_y_changed;
   } pot_flags_type;

endpackage

FILE: hdl/mlsi_scan.sv
// Stop-switch override of the motor word and scan-to-scan change detection.
// Depends on mlsi_pkg.
module mlsi_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  mlsi_pkg::stop_cfg_type        cfg,
   input  logic [mlsi_pkg::WORD_W-1:0]   commanded_outputs,
   input  logic [mlsi_pkg::WORD_W-1:0]   sampled_inputs,
   output logic [mlsi_pkg::WORD_W-1:0]   driven_outputs,
   output logic                          outputs_changed,
   output logic                          inputs_changed
);

   logic [mlsi_pkg::WORD_W-1:0] stop_active_ff, stop_active_in;
   logic [mlsi_pkg::WORD_W-1:0] prev_out_ff, prev_in_ff;
   logic [mlsi_pkg::WORD_W-1:0] drv;

   // forward check first, backward check sees its result
   always_comb begin
      logic [1:0] pair;
      drv = commanded_outputs;
      for (int m = 0; m < mlsi_pkg::MOTORS_CHECKED; m++) begin
         pair = commanded_outputs[2*m +: 2];
         if (stop_active_ff[2*m] && pair == mlsi_pkg::PAIR_FWD) begin
            pair = cfg.fwd_pattern[2*m +: 2];
         end
         if (stop_active_ff[2*m+1] && pair == mlsi_pkg::PAIR_BWD) begin
            pair = cfg.bwd_pattern[2*m +: 2];
         end
         drv[2*m +: 2] = pair;
      end
   end

   assign stop_active_in  = (sampled_inputs ^ cfg.stop_invert) & cfg.stop_enable;
   assign driven_outputs  = step ? drv : '0;
   assign outputs_changed = step && (drv != prev_out_ff);
   assign inputs_changed  = step && (sampled_inputs != prev_in_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_active_ff <= '0;
         prev_out_ff    <= '0;
         prev_in_ff     <= '0;
      end else if (step) begin
         stop_active_ff <= stop_active_in;
         prev_out_ff    <= drv;
         prev_in_ff     <= sampled_inputs;
      end
   end

endmodule

FILE: hdl/mlsi_pot.sv
// Potentiometer sequencer: alternates X/Y triggers and latches readings.
// Depends on mlsi_pkg and the assertion macro header.
`include "motor_limit_switch_interlock_macros.svh"

module mlsi_pot (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           monostable_busy,
   input  logic [mlsi_pkg::COUNT_W-1:0]   pulse_count,
   input  logic                           pulse_overflow,
   output mlsi_pkg::pot_flags_type        flags,
   output logic [mlsi_pkg::COUNT_W-1:0]   pot_x_value,
   output logic [mlsi_pkg::COUNT_W-1:0]   pot_y_value
);

   mlsi_pkg::pot_phase_type phase_ff, phase_in;
   logic [mlsi_pkg::COUNT_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [mlsi_pkg::COUNT_W-1:0] reading;

   assign reading = pulse_overflow ? mlsi_pkg::OVERFLOW_READING : pulse_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mlsi_pkg::POT_INIT;
         x_ff     <= '0;
         y_ff     <= '0;
      end else begin
         phase_ff <= phase_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flags    = '0;
      if (step && !monostable_busy) begin
         case (phase_ff)
            mlsi_pkg::POT_XDONE: begin
               flags.pot_x_changed = (reading != x_ff);
               x_in                = reading;
               flags.counter_clear = 1'b1;
               flags.trigger_y     = 1'b1;
               phase_in            = mlsi_pkg::POT_YDONE;
            end
            mlsi_pkg::POT_YDONE: begin
               flags.pot_y_changed = (reading != y_ff);
               y_in                = reading;
               flags.counter_clear = 1'b1;
               flags.trigger_x     = 1'b1;
               phase_in            = mlsi_pkg::POT_XDONE;
            end
            mlsi_pkg::POT_ARM: begin
               flags.counter_clear = 1'b1;
               flags.trigger_x     = 1'b1;
               phase_in            = mlsi_pkg::POT_XDONE;
            end
            default: begin
               phase_in = mlsi_pkg::POT_ARM;
            end
         endcase
      end
   end

   // readings after this scan
   assign pot_x_value = x_in;
   assign pot_y_value = y_in;

   `MLSI_ASSERT(a_x_read_phase, flags.pot_x_changed |-> phase_ff == mlsi_pkg::POT_XDONE, "X read outside X-done phase")
   `MLSI_ASSERT(a_phase_hold, (!step || monostable_busy) |=> $stable(phase_ff), "phase moved without a scan")

endmodule

FILE: hdl/motor_limit_switch_interlock.sv
// Motor limit-switch interlock: one scan word in, one result word out, every cycle unless stalled.
// Scan words pass an input register, single-pass logic (mlsi_scan, mlsi_pot) and a result
// register, so a word can be accepted each cycle while the result side is not stalled;
// rsp_tvalid rises once the input register hands its word on to a free result register.
// Throughput is one word per clock, set by the result register and its back pressure.
// Config writes (csr_*) take effect on the next edge and belong to idle periods; with the
// CSR_ENABLE bit clear, scans still return one result but leave all state alone.
`include "motor_limit_switch_interlock_macros.svh"

module motor_limit_switch_interlock (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] commanded_outputs, [31:16] sampled_inputs, [32] monostable_busy,
   // [40:33] pulse_count, [41] pulse_overflow, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] driven_outputs, [16] counter_clear, [17] trigger_x, [18] trigger_y,
   // [26:19] pot_x_value, [34:27] pot_y_value, [35] outputs_changed,
   // [36] inputs_changed, [37] pot_x_changed, [38] pot_y_changed, [39] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int W = mlsi_pkg::WORD_W;
   localparam int C = mlsi_pkg::COUNT_W;

   logic                   enable_ff;
   mlsi_pkg::stop_cfg_type cfg_ff;

   logic         s1_valid_ff;
   logic [W-1:0] s1_cmd_ff, s1_inp_ff;
   logic         s1_busy_ff, s1_ovf_ff;
   logic [C-1:0] s1_count_ff;

   logic         rsp_valid_ff;
   logic [39:0]  rsp_data_ff, rsp_data_in;

   logic advance, step;

   logic [W-1:0]            drv;
   logic                    och, ich;
   mlsi_pkg::pot_flags_type pflags;
   logic [C-1:0]            px, py;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         cfg_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mlsi_pkg::CSR_ENABLE:   enable_ff          <= csr_wdata[0];
            mlsi_pkg::CSR_STOP_EN:  cfg_ff.stop_enable <= csr_wdata;
            mlsi_pkg::CSR_STOP_INV: cfg_ff.stop_invert <= csr_wdata;
            mlsi_pkg::CSR_FWD_PAT:  cfg_ff.fwd_pattern <= csr_wdata;
            mlsi_pkg::CSR_BWD_PAT:  cfg_ff.bwd_pattern <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign step       = s1_valid_ff && advance && enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff   <= req_tdata[15:0];
         s1_inp_ff   <= req_tdata[31:16];
         s1_busy_ff  <= req_tdata[32];
         s1_count_ff <= req_tdata[40:33];
         s1_ovf_ff   <= req_tdata[41];
      end
   end

   mlsi_scan u_scan (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .cfg               (cfg_ff),
      .commanded_outputs (s1_cmd_ff),
      .sampled_inputs    (s1_inp_ff),
      .driven_outputs    (drv),
      .outputs_changed   (och),
      .inputs_changed    (ich)
   );

   mlsi_pot u_pot (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .monostable_busy (s1_busy_ff),
      .pulse_count     (s1_count_ff),
      .pulse_overflow  (s1_ovf_ff),
      .flags           (pflags),
      .pot_x_value     (px),
      .pot_y_value     (py)
   );

   assign rsp_data_in = {1'b0, pflags.pot_y_changed, pflags.pot_x_changed, ich, och,
                         py, px, pflags.trigger_y, pflags.trigger_x,
                         pflags.counter_clear, drv};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MLSI_ASSERT(a_one_trigger,
      rsp_valid_ff |-> !(rsp_data_ff[17] && rsp_data_ff[18]),
      "both triggers set")
   `MLSI_ASSERT(a_trig_clear,
      (rsp_valid_ff && (rsp_data_ff[17] || rsp_data_ff[18])) |-> rsp_data_ff[16],
      "trigger without counter clear")
   `MLSI_ASSERT(a_disabled_quiet,
      (s1_valid_ff && advance && !enable_ff) |=>
         (rsp_data_ff[18:0] == '0 && rsp_data_ff[38:35] == '0),
      "disabled scan drove outputs")
   `MLSI_ASSERT_ALWAYS(a_ready_when_empty,
      !rsp_valid_ff |-> req_tready,
      "input stalled with empty result register")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for motor_limit_switch_interlock: directed and random scan words
// with random idling on both streams, checked against a scoreboard class that predicts each
// result word. Depends on mlsi_pkg and the interlock RTL.

// req_tdata layout, lowest field last
typedef struct packed {
   logic [5:0]  pad;
   logic        overflow;
   logic [7:0]  count;
   logic        busy;
   logic [15:0] sampled;
   logic [15:0] commanded;
} scan_word_type;

// rsp_tdata layout, lowest field last
typedef struct packed {
   logic        pad;
   logic        pot_y_changed;
   logic        pot_x_changed;
   logic        inputs_changed;
   logic        outputs_changed;
   logic [7:0]  pot_y;
   logic [7:0]  pot_x;
   logic        trigger_y;
   logic        trigger_x;
   logic        counter_clear;
   logic [15:0] driven;
} result_word_type;

class interlock_scoreboard;
   logic                    enabled;
   logic [15:0]             stop_enable, stop_invert, fwd_pattern, bwd_pattern;
   logic [15:0]             stop_active, last_driven, last_sampled;
   mlsi_pkg::pot_phase_type phase;
   logic [7:0]              x_reading, y_reading;
   result_word_type         expected_q[$];
   int                      errors, scans, results, overrides, readings;

   function new();
      enabled      = 1'b0;
      stop_enable  = '0;
      stop_invert  = '0;
      fwd_pattern  = '0;
      bwd_pattern  = '0;
      stop_active  = '0;
      last_driven  = '0;
      last_sampled = '0;
      phase        = mlsi_pkg::POT_INIT;
      x_reading    = '0;
      y_reading    = '0;
      errors       = 0;
      scans        = 0;
      results      = 0;
      overrides    = 0;
      readings     = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
         mlsi_pkg::CSR_ENABLE:   enabled     = val[0];
         mlsi_pkg::CSR_STOP_EN:  stop_enable = val;
         mlsi_pkg::CSR_STOP_INV: stop_invert = val;
         mlsi_pkg::CSR_FWD_PAT:  fwd_pattern = val;
         mlsi_pkg::CSR_BWD_PAT:  bwd_pattern = val;
         default: ;
      endcase
   endfunction

   // predict the result of one accepted scan word
   function void note_scan(scan_word_type s);
      result_word_type r;
      logic [7:0]      reading;
      r = '0;
      scans++;
      if (enabled) begin
         reading = s.overflow ? mlsi_pkg::OVERFLOW_READING : s.count;
         r.driven = s.commanded;
         // forward check first, backward check sees its result
         for (int m = 0; m < mlsi_pkg::MOTORS_CHECKED; m++) begin
            if (stop_active[2*m] && r.driven[2*m +: 2] == mlsi_pkg::PAIR_FWD)
               r.driven[2*m +: 2] = fwd_pattern[2*m +: 2];
            if (stop_active[2*m+1] && r.driven[2*m +: 2] == mlsi_pkg::PAIR_BWD)
               r.driven[2*m +: 2] = bwd_pattern[2*m +: 2];
         end
         if (r.driven != s.commanded)
            overrides++;
         r.outputs_changed = (r.driven != last_driven);
         last_driven = r.driven;
         r.inputs_changed = (s.sampled != last_sampled);
         last_sampled = s.sampled;
         stop_active = (s.sampled ^ stop_invert) & stop_enable;
         if (!s.busy) begin
            case (phase)
               mlsi_pkg::POT_XDONE: begin
                  r.pot_x_changed = (reading != x_reading);
                  x_reading = reading;
                  r.counter_clear = 1'b1;
                  r.trigger_y = 1'b1;
                  phase = mlsi_pkg::POT_YDONE;
                  readings++;
               end
               mlsi_pkg::POT_YDONE: begin
                  r.pot_y_changed = (reading != y_reading);
                  y_reading = reading;
                  r.counter_clear = 1'b1;
                  r.trigger_x = 1'b1;
                  phase = mlsi_pkg::POT_XDONE;
                  readings++;
               end
               mlsi_pkg::POT_ARM: begin
                  r.counter_clear = 1'b1;
                  r.trigger_x = 1'b1;
                  phase = mlsi_pkg::POT_XDONE;
               end
               default: phase = mlsi_pkg::POT_ARM;
            endcase
         end
      end
      r.pot_x = x_reading;
      r.pot_y = y_reading;
      expected_q.push_back(r);
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: got %h, expected %h",
                                   results, name, got, want));
   endtask

   task check_word(result_word_type got);
      result_word_type want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("word %0d arrived with nothing expected", results));
      end else begin
         want = expected_q.pop_front();
         check_field("driven_outputs", got.driven, want.driven);
         check_field("counter_clear", got.counter_clear, want.counter_clear);
         check_field("trigger_x", got.trigger_x, want.trigger_x);
         check_field("trigger_y", got.trigger_y, want.trigger_y);
         check_field("pot_x_value", got.pot_x, want.pot_x);
         check_field("pot_y_value", got.pot_y, want.pot_y);
         check_field("outputs_changed", got.outputs_changed, want.outputs_changed);
         check_field("inputs_changed", got.inputs_changed, want.inputs_changed);
         check_field("pot_x_changed", got.pot_x_changed, want.pot_x_changed);
         check_field("pot_y_changed", got.pot_y_changed, want.pot_y_changed);
         check_field("pad", got.pad, want.pad);
      end
      results++;
   endtask
endclass

module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int RAND_PHASES = 6;
   localparam int RAND_SCANS  = 88;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   logic        gaps_on;
   int          settings;

   interlock_scoreboard sb;

   motor_limit_switch_interlock dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [15:0] pick_mask();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic scan_word_type make_scan(logic [15:0] cmd, logic [15:0] inp,
                                               logic busy, logic [7:0] count, logic ovf);
      scan_word_type s;
      s = '0;
      s.commanded = cmd;
      s.sampled   = inp;
      s.busy      = busy;
      s.count     = count;
      s.overflow  = ovf;
      return s;
   endfunction

   task automatic send_scan(scan_word_type s);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
   endtask

   // step past the current edge first so the last accepted word is already noted
   task automatic drain();
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // registers change only with the block idle
   task automatic program_regs(logic en, logic [15:0] stop_en, logic [15:0] stop_inv,
                               logic [15:0] fwd, logic [15:0] bwd);
      req_tvalid <= 1'b0;
      drain();
      write_reg(mlsi_pkg::CSR_ENABLE, {15'b0, en});
      write_reg(mlsi_pkg::CSR_STOP_EN, stop_en);
      write_reg(mlsi_pkg::CSR_STOP_INV, stop_inv);
      write_reg(mlsi_pkg::CSR_FWD_PAT, fwd);
      write_reg(mlsi_pkg::CSR_BWD_PAT, bwd);
      csr_we <= 1'b0;
      settings++;
   endtask

   // result side: random back pressure
   initial begin : rsp_sink
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0)
            hold--;
         else if (gaps_on)
            hold = pick_gap();
         rsp_tready <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_scan(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata);
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      scan_word_type s;
      logic [15:0]   last_cmd, last_inp;
      logic [15:0]   cmd, inp;
      logic [7:0]    count;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      gaps_on    = 1'b1;
      settings   = 0;
      last_cmd   = '0;
      last_inp   = '0;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: result still returned, state untouched
      send_scan(make_scan(16'h5555, 16'hFFFF, 1'b0, 8'h10, 1'b0));
      send_scan(make_scan(16'hFFFF, 16'h0000, 1'b0, 8'hFF, 1'b1));

      program_regs(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_scan(make_scan(16'h5555, 16'hFFFF, 1'b0, 8'h00, 1'b0));
      send_scan(make_scan(16'h5555, 16'hFFFF, 1'b0, 8'h12, 1'b0));
      send_scan(make_scan(16'hAAAA, 16'h0000, 1'b0, 8'hFF, 1'b0));
      send_scan(make_scan(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 1'b1));
      send_scan(make_scan(16'h0000, 16'h5555, 1'b1, 8'h34, 1'b0));
      send_scan(make_scan(16'h5555, 16'h5555, 1'b0, 8'h00, 1'b0));
      send_scan(make_scan(16'hAAAA, 16'hAAAA, 1'b0, 8'h00, 1'b0));
      send_scan(make_scan(16'hAAAA, 16'hAAAA, 1'b0, 8'h00, 1'b0));
      send_scan(make_scan(16'h5555, 16'h0000, 1'b0, 8'h00, 1'b0));

      // inverted sense; forward stop yields backward pair which the backward check catches
      program_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555);
      send_scan(make_scan(16'h5555, 16'h0000, 1'b0, 8'h80, 1'b0));
      send_scan(make_scan(16'h5555, 16'h0000, 1'b0, 8'h80, 1'b0));
      send_scan(make_scan(16'hAAAA, 16'hFFFF, 1'b0, 8'h7F, 1'b0));
      send_scan(make_scan(16'h9C63, 16'hFFFF, 1'b1, 8'h00, 1'b0));

      program_regs(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_scan(make_scan(16'h5555, 16'h0000, 1'b0, 8'hFF, 1'b1));
      send_scan(make_scan(16'hAAAA, 16'hFFFF, 1'b0, 8'h00, 1'b1));

      program_regs(1'b1, 16'h00FF, 16'h0F0F, 16'h3333, 16'hCCCC);
      send_scan(make_scan(16'h6A95, 16'h0F0F, 1'b0, 8'h01, 1'b0));
      send_scan(make_scan(16'h6A95, 16'hF0F0, 1'b0, 8'h02, 1'b0));
      send_scan(make_scan(16'hA956, 16'h0000, 1'b0, 8'h03, 1'b0));

      // disabled mid sequence: phase and readings must hold
      program_regs(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_scan(make_scan(16'h1234, 16'hFFFF, 1'b0, 8'h55, 1'b0));
      send_scan(make_scan(16'h4321, 16'h0000, 1'b0, 8'hAA, 1'b1));

      program_regs(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_scan(make_scan(16'h5555, 16'h0000, 1'b0, 8'h11, 1'b0));
      send_scan(make_scan(16'hAAAA, 16'hFFFF, 1'b0, 8'h22, 1'b0));

      for (int p = 0; p < RAND_PHASES; p++) begin
         program_regs(p != 3, pick_mask(), pick_mask(), pick_mask(), pick_mask());
         gaps_on = (p % 3 != 2);
         for (int n = 0; n < RAND_SCANS; n++) begin
            // repeats keep change flags and readings steady now and then
            cmd   = ($urandom_range(0, 3) == 0) ? last_cmd : 16'($urandom_range(0, 16'hFFFF));
            inp   = ($urandom_range(0, 3) == 0) ? last_inp : 16'($urandom_range(0, 16'hFFFF));
            count = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 2))
                                                : 8'($urandom_range(0, 255));
            s = make_scan(cmd, inp, $urandom_range(0, 3) == 0, count,
                          $urandom_range(0, 4) == 0);
            send_scan(s);
            last_cmd = cmd;
            last_inp = inp;
         end
      end

      req_tvalid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d expected words never arrived",
                                      sb.expected_q.size()));
      $display("covered %0d scans, %0d result words checked, %0d register settings",
               sb.scans, sb.results, settings);
      $display("%0d scans had a stop override, %0d pot readings taken",
               sb.overrides, sb.readings);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mlsi_pkg.sv
hdl/mlsi_scan.sv
hdl/mlsi_pot.sv
hdl/motor_limit_switch_interlock.sv
sim/testbench.sv
